// ===== sv/idea_pkg.sv =====
// Shared constants and arithmetic helpers for the IDEA chaining-mode unit.
// Holds the register index codes, chaining mode codes, the mod 65537 multiply
// and the key-schedule word extractor. No dependencies.
package idea_pkg;

   localparam int ROUND_COUNT  = 8;
   localparam int SUBKEY_COUNT = 6 * ROUND_COUNT + 4;
   localparam int SK_AW        = $clog2(SUBKEY_COUNT);
   localparam int KA_W         = $clog2(SUBKEY_COUNT + 1);
   localparam int RND_W        = $clog2(ROUND_COUNT + 1);

   localparam logic [2:0] CSR_KEY_HIGH    = 3'd0;
   localparam logic [2:0] CSR_KEY_LOW     = 3'd1;
   localparam logic [2:0] CSR_INIT_VECTOR = 3'd2;
   localparam logic [2:0] CSR_CHAIN_MODE  = 3'd3;
   localparam logic [2:0] CSR_DECRYPT     = 3'd4;

   localparam logic [1:0] MODE_ECB = 2'd0;
   localparam logic [1:0] MODE_CBC = 2'd1;
   localparam logic [1:0] MODE_CFB = 2'd2;
   localparam logic [1:0] MODE_OFB = 2'd3;

   // Multiply modulo 65537, word 0 stands for 65536 (low-high reduction).
   function automatic logic [15:0] mmul(input logic [15:0] a, input logic [15:0] b);
      logic [31:0] p;
      logic [15:0] lo;
      logic [15:0] hi;
      p  = 32'(a) * 32'(b);
      lo = p[15:0];
      hi = p[31:16];
      if (a == 16'd0) begin
         return 16'd1 - b;
      end else if (b == 16'd0) begin
         return 16'd1 - a;
      end else begin
         return lo - hi + {15'd0, (lo < hi)};
      end
   endfunction

   // Encryption subkey n: word n%8 of the key rotated left by 25*(n/8).
   function automatic logic [15:0] enc_word(input logic [127:0] k,
                                            input logic [SK_AW-1:0] n);
      logic [SK_AW-1:0] g;
      logic [6:0]       sh;
      logic [255:0]     dbl;
      logic [2:0]       w;
      g   = n >> 3;
      sh  = 7'((25 * int'(g)) % 128);
      dbl = {k, k} << sh;
      w   = n[2:0];
      return dbl[255 - 16 * int'(w) -: 16];
   endfunction

endpackage

// ===== sv/idea_block_cipher_modes_unit.sv =====
// IDEA block cipher with ECB/CBC/CFB/OFB chaining, single-multiplier datapath.
// Depends on idea_pkg (constants, mmul, enc_word).
//
// One transaction on req_ transforms one 64-bit block and yields one transaction on
// rsp_. All mod 65537 products, both for the cipher rounds and for the subkey
// inverses, go through one shared multiplier under a small sequencer; subkeys are
// read one per cycle, on the steps that use one, from two 16-bit subkey memories. A
// block passes a memory fetch state, then per round four multiplier slots, adds and
// mix, then the output transform (x1 and x4 multiplies, the two adds), then a result
// state, before req_stall drops again. The result waits in an output register, so
// the next block may be accepted while it is still stalled on rsp_. After reset and
// after every write of key_high or key_low the unit rebuilds both subkey stores:
// each subkey word is written in turn and each of the 2*(ROUND_COUNT+1) inverses
// adds a square-and-multiply run to the power 65535; req_stall stays high meanwhile.
// A start_chain block reloads the chain value from init_vector in every mode.
module idea_block_cipher_modes_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_in_block,
   input  logic        req_start_chain,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_out_block,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_KS_WORD,
      ST_KS_INV,
      ST_IDLE,
      ST_FETCH,
      ST_RUN,
      ST_DONE
   } state_type;

   // round steps
   localparam logic [2:0] STEP_MUL_X1 = 3'd0;
   localparam logic [2:0] STEP_ADD_X2 = 3'd1;
   localparam logic [2:0] STEP_ADD_X3 = 3'd2;
   localparam logic [2:0] STEP_MUL_X4 = 3'd3;
   localparam logic [2:0] STEP_MUL_KA = 3'd4;
   localparam logic [2:0] STEP_SUM    = 3'd5;
   localparam logic [2:0] STEP_MUL_KB = 3'd6;
   localparam logic [2:0] STEP_MIX    = 3'd7;

   localparam int SK_AW_L = idea_pkg::SK_AW;
   localparam logic [SK_AW_L-1:0] BASE_START = SK_AW_L'(6 * idea_pkg::ROUND_COUNT);

   state_type state_ff;

   // configuration
   logic [63:0] key_high_ff;
   logic [63:0] key_low_ff;
   logic [63:0] iv_ff;
   logic [1:0]  mode_ff;
   logic        dec_ff;

   // chain and block
   logic [63:0] chain_ff;
   logic [63:0] blk_ff;
   logic        dec_sel_ff;

   // cipher datapath
   logic [15:0] x1_ff, x2_ff, x3_ff, x4_ff, ta_ff, tb_ff;
   logic [idea_pkg::RND_W-1:0] round_ff;
   logic [2:0]                 step_ff;
   logic [idea_pkg::KA_W-1:0]  kaddr_ff;
   logic [15:0]                key_rd_ff;

   // key schedule
   logic [SK_AW_L-1:0]         ks_d_ff;
   logic [2:0]                 ks_j_ff;
   logic [idea_pkg::RND_W-1:0] ks_grp_ff;
   logic [SK_AW_L-1:0]         ks_base_ff;
   logic [15:0]                ks_a_ff;
   logic [15:0]                ks_r_ff;
   logic [3:0]                 inv_cnt_ff;
   logic                       inv_ph_ff;

   // result
   logic        rsp_valid_ff;
   logic [63:0] rsp_out_ff;

   // subkey memories
   logic [15:0] enc_mem [idea_pkg::SUBKEY_COUNT];
   logic [15:0] dec_mem [idea_pkg::SUBKEY_COUNT];

   logic [127:0]       key128;
   logic               ks_swap;
   logic [SK_AW_L-1:0] ks_se;
   logic [15:0]        ks_src;
   logic [15:0]        ks_enc;
   logic               ks_inv_pos;
   logic               ks_last;
   logic               enc_we;
   logic               dec_we;
   logic [15:0]        dec_wdata;
   logic [15:0]        mul_a, mul_b, mul_p;
   logic               last_round;
   logic               consume;
   logic               rd_en;
   logic [15:0]        mix_x3n;
   logic [63:0]        cipher_out;
   logic [63:0]        res;
   logic [63:0]        chain_next;
   logic [63:0]        chain_cur;
   logic [63:0]        cipher_in;
   logic               accept;
   logic               key_write;

   assign key128    = {key_high_ff, key_low_ff};
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign key_write = csr_wen && ((csr_index == idea_pkg::CSR_KEY_HIGH) ||
                                  (csr_index == idea_pkg::CSR_KEY_LOW));
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_block = rsp_out_ff;

   // Key schedule: pick the encryption subkey feeding decryption subkey ks_d.
   // The first and last groups keep the add keys in order; inner groups swap them.
   always_comb begin
      ks_swap = (ks_grp_ff != '0) &&
                (ks_grp_ff != idea_pkg::RND_W'(idea_pkg::ROUND_COUNT));
      case (ks_j_ff)
         3'd0:    ks_se = ks_base_ff;
         3'd1:    ks_se = ks_base_ff + (ks_swap ? SK_AW_L'(2) : SK_AW_L'(1));
         3'd2:    ks_se = ks_base_ff + (ks_swap ? SK_AW_L'(1) : SK_AW_L'(2));
         3'd3:    ks_se = ks_base_ff + SK_AW_L'(3);
         3'd4:    ks_se = ks_base_ff - SK_AW_L'(2);
         default: ks_se = ks_base_ff - SK_AW_L'(1);
      endcase
      ks_src     = idea_pkg::enc_word(key128, ks_se);
      ks_enc     = idea_pkg::enc_word(key128, ks_d_ff);
      ks_inv_pos = (ks_j_ff == 3'd0) || (ks_j_ff == 3'd3);
      ks_last    = (ks_d_ff == SK_AW_L'(idea_pkg::SUBKEY_COUNT - 1));
      enc_we     = (state_ff == ST_KS_WORD);
      dec_we     = ((state_ff == ST_KS_WORD) && !ks_inv_pos) ||
                   ((state_ff == ST_KS_INV) && inv_ph_ff && (inv_cnt_ff == 4'd14));
      if (state_ff == ST_KS_WORD) begin
         dec_wdata = ((ks_j_ff == 3'd1) || (ks_j_ff == 3'd2)) ? (16'd0 - ks_src) : ks_src;
      end else begin
         dec_wdata = mul_p;
      end
   end

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = x1_ff;
      mul_b = key_rd_ff;
      if (state_ff == ST_KS_INV) begin
         mul_a = ks_r_ff;
         mul_b = inv_ph_ff ? ks_a_ff : ks_r_ff;
      end else begin
         case (step_ff)
            STEP_MUL_X4: mul_a = x4_ff;
            STEP_MUL_KA: mul_a = x3_ff ^ x1_ff;
            STEP_MUL_KB: mul_a = tb_ff;
            default:     mul_a = x1_ff;
         endcase
      end
      mul_p = idea_pkg::mmul(mul_a, mul_b);
   end

   // Subkey fetch control: a step that uses a subkey advances the read pointer.
   always_comb begin
      last_round = (round_ff == idea_pkg::RND_W'(idea_pkg::ROUND_COUNT));
      consume    = last_round || ((step_ff != STEP_SUM) && (step_ff != STEP_MIX));
      rd_en      = ((state_ff == ST_FETCH) || ((state_ff == ST_RUN) && consume)) &&
                   (kaddr_ff < idea_pkg::KA_W'(idea_pkg::SUBKEY_COUNT));
      mix_x3n    = ta_ff + tb_ff;
   end

   // Chaining around the cipher.
   always_comb begin
      chain_cur = req_start_chain ? iv_ff : chain_ff;
      case (mode_ff)
         idea_pkg::MODE_ECB: cipher_in = req_in_block;
         idea_pkg::MODE_CBC: cipher_in = dec_ff ? req_in_block : (chain_cur ^ req_in_block);
         default:            cipher_in = chain_cur;
      endcase
      cipher_out = {x1_ff, x3_ff, x2_ff, x4_ff};
      case (mode_ff)
         idea_pkg::MODE_ECB: begin
            res        = cipher_out;
            chain_next = chain_ff;
         end
         idea_pkg::MODE_CBC: begin
            res        = dec_ff ? (chain_ff ^ cipher_out) : cipher_out;
            chain_next = dec_ff ? blk_ff : cipher_out;
         end
         idea_pkg::MODE_CFB: begin
            res        = blk_ff ^ cipher_out;
            chain_next = dec_ff ? blk_ff : (blk_ff ^ cipher_out);
         end
         default: begin
            res        = blk_ff ^ cipher_out;
            chain_next = cipher_out;
         end
      endcase
   end

   // Subkey memories with registered read.
   always_ff @(posedge clock) begin
      if (enc_we) begin
         enc_mem[ks_d_ff] <= ks_enc;
      end
      if (dec_we) begin
         dec_mem[ks_d_ff] <= dec_wdata;
      end
      if (rd_en) begin
         key_rd_ff <= dec_sel_ff ? dec_mem[kaddr_ff[SK_AW_L-1:0]]
                                 : enc_mem[kaddr_ff[SK_AW_L-1:0]];
      end
   end

   // Sequencer, configuration and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_KS_WORD;
         key_high_ff  <= '0;
         key_low_ff   <= '0;
         iv_ff        <= '0;
         mode_ff      <= idea_pkg::MODE_ECB;
         dec_ff       <= 1'b0;
         chain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         ks_d_ff      <= '0;
         ks_j_ff      <= '0;
         ks_grp_ff    <= '0;
         ks_base_ff   <= BASE_START;
         inv_cnt_ff   <= '0;
         inv_ph_ff    <= 1'b0;
         round_ff     <= '0;
         step_ff      <= STEP_MUL_X1;
         kaddr_ff     <= '0;
         dec_sel_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // advance the schedule counters after each decryption subkey
         if (dec_we) begin
            ks_d_ff <= ks_d_ff + SK_AW_L'(1);
            if (ks_j_ff == 3'd5) begin
               ks_j_ff    <= '0;
               ks_grp_ff  <= ks_grp_ff + idea_pkg::RND_W'(1);
               ks_base_ff <= ks_base_ff - SK_AW_L'(6);
            end else begin
               ks_j_ff <= ks_j_ff + 3'd1;
            end
         end

         if (rd_en) begin
            kaddr_ff <= kaddr_ff + idea_pkg::KA_W'(1);
         end

         case (state_ff)
            ST_KS_WORD: begin
               if (ks_inv_pos) begin
                  ks_a_ff    <= ks_src;
                  ks_r_ff    <= ks_src;
                  inv_cnt_ff <= '0;
                  inv_ph_ff  <= 1'b0;
                  state_ff   <= ST_KS_INV;
               end else if (ks_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_KS_INV: begin
               ks_r_ff   <= mul_p;
               inv_ph_ff <= !inv_ph_ff;
               if (inv_ph_ff) begin
                  inv_cnt_ff <= inv_cnt_ff + 4'd1;
               end
               if (dec_we) begin
                  state_ff <= ks_last ? ST_IDLE : ST_KS_WORD;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  chain_ff   <= chain_cur;
                  blk_ff     <= req_in_block;
                  x1_ff      <= cipher_in[63:48];
                  x2_ff      <= cipher_in[47:32];
                  x3_ff      <= cipher_in[31:16];
                  x4_ff      <= cipher_in[15:0];
                  dec_sel_ff <= dec_ff && ((mode_ff == idea_pkg::MODE_ECB) ||
                                           (mode_ff == idea_pkg::MODE_CBC));
                  kaddr_ff   <= '0;
                  round_ff   <= '0;
                  step_ff    <= STEP_MUL_X1;
                  state_ff   <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               if (last_round) begin
                  // output transform: x3 and x2 take the add keys in swapped order
                  case (step_ff)
                     STEP_MUL_X1: x1_ff <= mul_p;
                     STEP_ADD_X2: x3_ff <= x3_ff + key_rd_ff;
                     STEP_ADD_X3: x2_ff <= x2_ff + key_rd_ff;
                     default: begin
                        x4_ff    <= mul_p;
                        state_ff <= ST_DONE;
                     end
                  endcase
                  step_ff <= step_ff + 3'd1;
               end else begin
                  case (step_ff)
                     STEP_MUL_X1: x1_ff <= mul_p;
                     STEP_ADD_X2: x2_ff <= x2_ff + key_rd_ff;
                     STEP_ADD_X3: x3_ff <= x3_ff + key_rd_ff;
                     STEP_MUL_X4: x4_ff <= mul_p;
                     STEP_MUL_KA: ta_ff <= mul_p;
                     STEP_SUM:    tb_ff <= (x2_ff ^ x4_ff) + ta_ff;
                     STEP_MUL_KB: tb_ff <= mul_p;
                     default: begin
                        x1_ff    <= x1_ff ^ tb_ff;
                        x4_ff    <= x4_ff ^ mix_x3n;
                        x2_ff    <= tb_ff ^ x3_ff;
                        x3_ff    <= mix_x3n ^ x2_ff;
                        round_ff <= round_ff + idea_pkg::RND_W'(1);
                     end
                  endcase
                  step_ff <= step_ff + 3'd1;
               end
            end
            ST_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_out_ff   <= res;
                  rsp_valid_ff <= 1'b1;
                  chain_ff     <= chain_next;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         if (csr_wen) begin
            case (csr_index)
               idea_pkg::CSR_KEY_HIGH:    key_high_ff <= csr_wdata;
               idea_pkg::CSR_KEY_LOW:     key_low_ff  <= csr_wdata;
               idea_pkg::CSR_INIT_VECTOR: iv_ff       <= csr_wdata;
               idea_pkg::CSR_CHAIN_MODE:  mode_ff     <= csr_wdata[1:0];
               idea_pkg::CSR_DECRYPT:     dec_ff      <= csr_wdata[0];
               default: ;
            endcase
         end

         // restart the schedule on any key write
         if (key_write) begin
            state_ff   <= ST_KS_WORD;
            ks_d_ff    <= '0;
            ks_j_ff    <= '0;
            ks_grp_ff  <= '0;
            ks_base_ff <= BASE_START;
         end
      end
   end

endmodule

// ===== verif/idea_block_cipher_modes_checker.sv =====
// Checker for the IDEA chaining-mode unit: tracks register writes, predicts each
// output block and compares it with the rsp_ channel. Depends on idea_pkg for
// register and mode codes.
`timescale 1ns / 100ps
module idea_block_cipher_modes_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [63:0] req_in_block,
   input  logic        req_start_chain,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_out_block,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output int          error_count,
   output int          pending
);

   logic [15:0] enc_sk [idea_pkg::SUBKEY_COUNT];
   logic [15:0] dec_sk [idea_pkg::SUBKEY_COUNT];
   logic [63:0] key_hi, key_lo, iv, chain;
   logic [1:0]  mode;
   logic        dir_dec;
   logic [63:0] expected_blocks [$];

   function automatic logic [15:0] mulmod(input logic [15:0] a, input logic [15:0] b);
      logic [33:0] x, y;
      x = (a == 16'd0) ? 34'd65536 : 34'(a);
      y = (b == 16'd0) ? 34'd65536 : 34'(b);
      return 16'((x * y) % 34'd65537);
   endfunction

   function automatic logic [15:0] invmod(input logic [15:0] a);
      logic [33:0] base, r;
      int e;
      base = (a == 16'd0) ? 34'd65536 : 34'(a);
      r = 34'd1;
      e = 65535;
      while (e != 0) begin
         if (e[0]) r = (r * base) % 34'd65537;
         base = (base * base) % 34'd65537;
         e = e >> 1;
      end
      return r[15:0];
   endfunction

   // expand the key into both subkey stores
   task automatic expand_key();
      logic [127:0] k;
      int b, e, d;
      k = {key_hi, key_lo};
      for (int n = 0; n < idea_pkg::SUBKEY_COUNT; n++) begin
         if (n > 0 && n % 8 == 0) k = {k[102:0], k[127:103]};
         enc_sk[n] = k[127 - 16 * (n % 8) -: 16];
      end
      b = 6 * idea_pkg::ROUND_COUNT;
      dec_sk[0] = invmod(enc_sk[b]);
      dec_sk[1] = -enc_sk[b + 1];
      dec_sk[2] = -enc_sk[b + 2];
      dec_sk[3] = invmod(enc_sk[b + 3]);
      dec_sk[4] = enc_sk[b - 2];
      dec_sk[5] = enc_sk[b - 1];
      for (int i = 1; i < idea_pkg::ROUND_COUNT; i++) begin
         e = 6 * (idea_pkg::ROUND_COUNT - i);
         d = 6 * i;
         dec_sk[d]     = invmod(enc_sk[e]);
         dec_sk[d + 1] = -enc_sk[e + 2];
         dec_sk[d + 2] = -enc_sk[e + 1];
         dec_sk[d + 3] = invmod(enc_sk[e + 3]);
         dec_sk[d + 4] = enc_sk[e - 2];
         dec_sk[d + 5] = enc_sk[e - 1];
      end
      dec_sk[b]     = invmod(enc_sk[0]);
      dec_sk[b + 1] = -enc_sk[1];
      dec_sk[b + 2] = -enc_sk[2];
      dec_sk[b + 3] = invmod(enc_sk[3]);
   endtask

   function automatic logic [63:0] idea_transform(input logic [63:0] blk, input logic use_dec);
      logic [15:0] k [idea_pkg::SUBKEY_COUNT];
      logic [15:0] x1, x2, x3, x4, s2, s3;
      int p;
      if (use_dec) k = dec_sk;
      else k = enc_sk;
      {x1, x2, x3, x4} = blk;
      p = 0;
      for (int r = 0; r < idea_pkg::ROUND_COUNT; r++) begin
         x1 = mulmod(x1, k[p]);
         x2 = x2 + k[p + 1];
         x3 = x3 + k[p + 2];
         x4 = mulmod(x4, k[p + 3]);
         s3 = x3;
         x3 = mulmod(x3 ^ x1, k[p + 4]);
         s2 = x2;
         x2 = mulmod((x2 ^ x4) + x3, k[p + 5]);
         x3 = x3 + x2;
         x1 = x1 ^ x2;
         x4 = x4 ^ x3;
         x2 = x2 ^ s3;
         x3 = x3 ^ s2;
         p += 6;
      end
      return {mulmod(x1, k[p]), 16'(x3 + k[p + 1]), 16'(x2 + k[p + 2]), mulmod(x4, k[p + 3])};
   endfunction

   function automatic logic [63:0] chain_step(input logic [63:0] blk);
      logic [63:0] res, g;
      case (mode)
         idea_pkg::MODE_ECB: res = idea_transform(blk, dir_dec);
         idea_pkg::MODE_CBC: begin
            if (dir_dec) begin
               res = chain ^ idea_transform(blk, 1'b1);
               chain = blk;
            end else begin
               res = idea_transform(chain ^ blk, 1'b0);
               chain = res;
            end
         end
         idea_pkg::MODE_CFB: begin
            g = idea_transform(chain, 1'b0);
            res = blk ^ g;
            chain = dir_dec ? blk : res;
         end
         default: begin
            g = idea_transform(chain, 1'b0);
            res = blk ^ g;
            chain = g;
         end
      endcase
      return res;
   endfunction

   assign pending = expected_blocks.size();

   always @(posedge clock) begin
      logic [63:0] want;
      if (reset) begin
         key_hi = '0;
         key_lo = '0;
         iv = '0;
         chain = '0;
         mode = idea_pkg::MODE_ECB;
         dir_dec = 1'b0;
         expected_blocks.delete();
         error_count = 0;
         expand_key();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               idea_pkg::CSR_KEY_HIGH: begin key_hi = csr_wdata; expand_key(); end
               idea_pkg::CSR_KEY_LOW: begin key_lo = csr_wdata; expand_key(); end
               idea_pkg::CSR_INIT_VECTOR: iv = csr_wdata;
               idea_pkg::CSR_CHAIN_MODE: mode = csr_wdata[1:0];
               idea_pkg::CSR_DECRYPT: dir_dec = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_start_chain) chain = iv;
            expected_blocks.push_back(chain_step(req_in_block));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_blocks.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_out_block);
               error_count++;
            end else begin
               want = expected_blocks.pop_front();
               if (want !== rsp_out_block) begin
                  $display("%0t: out_block mismatch, expected %h actual %h",
                           $time, want, rsp_out_block);
                  error_count++;
               end
            end
         end
      end
   end

endmodule

// ===== verif/idea_block_cipher_modes_unit_test.sv =====
// Top of the IDEA chaining-mode unit testbench: clock, reset, stimulus and verdict.
// Depends on idea_pkg, the unit and idea_block_cipher_modes_checker.
`timescale 1ns / 100ps
module idea_block_cipher_modes_unit_test;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_in_block;
   logic        req_start_chain;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_out_block;
   logic        csr_wen;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;
   int          error_count;
   int          pending;
   int          quiet_cycles;
   bit          quiet;     // no idling on either side
   bit          hold_req;  // ask the receiver for one long hold-off

   idea_block_cipher_modes_unit dut (.*);
   idea_block_cipher_modes_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Watchdog: count cycles in which no transaction moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= 8000) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            hold_req = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Write one register; hold the enable for exactly one rising edge.
   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   // Offer one block; optionally drop valid for a random gap first.
   task automatic send_block(input logic [63:0] blk, input logic sc);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_block <= blk;
      req_start_chain <= sc;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drop valid, wait for all results, then let the unit settle.
   task automatic drain();
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (80) @(negedge clock);
   endtask

   function automatic logic [63:0] rand_block();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         2: return {4{16'h0000 | 16'($urandom_range(0, 1))}};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      logic [63:0] edge_blocks [6];
      edge_blocks = '{64'h0, '1, 64'h0000_FFFF_0000_FFFF, 64'h8000_0000_0000_0001,
                      64'h0001_0001_0001_0001, 64'hFFFF_0000_FFFF_0000};
      quiet = 1'b0;
      hold_req = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_block = '0;
      req_start_chain = 1'b0;
      csr_wen = 1'b0;
      csr_index = idea_pkg::CSR_KEY_HIGH;
      csr_wdata = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed: edge blocks under the reset key, then every mode and direction.
      foreach (edge_blocks[i]) send_block(edge_blocks[i], i[0]);
      drain();
      write_reg(idea_pkg::CSR_KEY_HIGH, '1);
      write_reg(idea_pkg::CSR_KEY_LOW, 64'h0000_1234_0000_FFFF);
      write_reg(idea_pkg::CSR_INIT_VECTOR, '1);
      for (int m = 0; m < 8; m++) begin
         write_reg(idea_pkg::CSR_CHAIN_MODE, 64'(m % 4));
         write_reg(idea_pkg::CSR_DECRYPT, 64'(m / 4));
         send_block('0, 1'b1);
         send_block('1, 1'b0);
         drain();
      end
      // Out-of-range index must be ignored.
      write_reg(3'd5, '1);
      write_reg(3'd7, '1);

      // Random phases: every mode/direction, wide register values, fresh keys.
      for (int p = 0; p < 12; p++) begin
         if (p == 11) quiet = 1'b1;
         write_reg(idea_pkg::CSR_KEY_HIGH, (p == 0) ? 64'h0 : {$urandom, $urandom});
         write_reg(idea_pkg::CSR_KEY_LOW, (p == 0) ? 64'h0 : {$urandom, $urandom});
         write_reg(idea_pkg::CSR_INIT_VECTOR, (p == 1) ? '0 : {$urandom, $urandom});
         write_reg(idea_pkg::CSR_CHAIN_MODE, {$urandom, 30'($urandom), 2'(p % 4)});
         write_reg(idea_pkg::CSR_DECRYPT, {$urandom, 31'($urandom), 1'((p / 4) % 2)});
         if (p == 5) hold_req = 1'b1;
         for (int i = 0; i < 54; i++)
            send_block(rand_block(), (i == 0) || ($urandom_range(0, 9) == 0));
         drain();
      end

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/idea_pkg.sv
sv/idea_block_cipher_modes_unit.sv
verif/idea_block_cipher_modes_checker.sv
verif/idea_block_cipher_modes_unit_test.sv
